// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands used by the checker file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion with explicit clock and active-low reset.
`define ASSERT_AT(label, clk_sig, rst_n_sig, prop, msg) \
	label: assert property (@(posedge clk_sig) disable iff (!rst_n_sig) prop) else $error(msg);

// Clocked assertion on the block clock and reset.
`define ASSERT_CLK(label, prop, msg) \
	`ASSERT_AT(label, clk, arst_n, prop, msg)

`endif

// ===== rtl/core/tgl_pkg.sv =====
// ----------------------------------------------------------------------------
// tgl_pkg
// Types, codes and helpers for the text glyph layout unit.
// ----------------------------------------------------------------------------
package tgl_pkg;

	localparam int unsigned COORD_BITS_DEF = 16;

	// Opcodes
	localparam logic [1:0] OP_CHAR = 2'd0;
	localparam logic [1:0] OP_END  = 2'd1;
	localparam logic [1:0] OP_ROW  = 2'd2;
	localparam logic [1:0] OP_PIX  = 2'd3;

	// Result kinds
	localparam logic KIND_GLYPH = 1'b0;
	localparam logic KIND_BOX   = 1'b1;

	// Register indexes
	localparam int unsigned CFG_IDX_BITS = 3;
	localparam logic [CFG_IDX_BITS-1:0] REG_PAD_H    = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_PAD_V    = 3'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_LINE_GAP = 3'd2;
	localparam logic [CFG_IDX_BITS-1:0] REG_SCREEN_W = 3'd3;
	localparam logic [CFG_IDX_BITS-1:0] REG_MODE     = 3'd4;
	localparam logic [CFG_IDX_BITS-1:0] REG_FG       = 3'd5;
	localparam logic [CFG_IDX_BITS-1:0] REG_BG       = 3'd6;

	// Register reset values
	localparam logic [11:0] SCREEN_W_RST = 12'd640;
	localparam logic [31:0] FG_RST       = 32'hFFFF_FFFF;
	localparam logic [31:0] BG_RST       = 32'h0000_00FF;

	// Character set
	localparam logic [7:0] CHAR_NL    = 8'h0A;
	localparam logic [7:0] CHAR_FIRST = 8'h20;
	localparam logic [7:0] CHAR_LAST  = 8'h7E;

	typedef struct packed {
		logic [1:0]         opcode;
		logic [7:0]         char_code;
		logic signed [15:0] arg_a;
		logic signed [15:0] arg_b;
	} item_t;

	typedef struct packed {
		logic               kind;
		logic signed [15:0] left;
		logic signed [15:0] top;
		logic signed [15:0] right;
		logic signed [15:0] bottom;
		logic [6:0]         tex_left;
		logic [7:0]         tex_top;
		logic [6:0]         tex_right;
		logic [7:0]         tex_bottom;
		logic [31:0]        color;
	} result_t;

	typedef struct packed {
		logic [7:0]  pad_horizontal;
		logic [7:0]  pad_vertical;
		logic [7:0]  line_gap;
		logic [11:0] screen_width;
		logic        pass_mode;
		logic [31:0] glyph_color;
		logic [31:0] box_color;
	} cfg_t;

	typedef struct packed {
		logic [6:0] tex_left;
		logic [7:0] tex_top;
		logic [6:0] tex_right;
		logic [7:0] tex_bottom;
	} tex_t;

	// Font sheet cell of a printable character: 10 cells of 8x16 per row.
	// Divide by ten through a reciprocal multiply, exact for indexes below 128.
	function automatic tex_t glyph_tex(logic [7:0] code);
		logic [6:0]  idx;
		logic [14:0] prod;
		logic [3:0]  q;
		logic [6:0]  q10;
		logic [3:0]  r;
		tex_t        t;
		idx  = 7'(code - CHAR_FIRST);
		prod = 15'(idx) * 15'd205;
		q    = prod[14:11];
		q10  = {q, 3'b000} + {2'b00, q, 1'b0};
		r    = 4'(idx - q10);
		t.tex_left   = {r, 3'b000};
		t.tex_right  = {r, 3'b000} + 7'd8;
		t.tex_top    = {q, 4'b0000};
		t.tex_bottom = {q, 4'b0000} + 8'd15;
		return t;
	endfunction

endpackage

// ===== rtl/core/text_glyph_layout_unit.sv =====
// ----------------------------------------------------------------------------
// text_glyph_layout_unit
// Text overlay layout: characters in, glyph quads or line boxes out.
// ----------------------------------------------------------------------------
// Takes one item per clock while the output is not stalled and gives at most
// one result per item. An item is captured in an input register, laid out
// against the cursor state, and its result lands in an output register. The
// sustained rate is one item per cycle while results are drained, set by the
// cursor update loop, combinational between the registered cursor state
// (saturating adds and the row-height multiply for row/column positioning).
// A stalled result holds the layout stage; the input register then takes
// one more item only if it is empty.
// Configuration writes take effect on the next clock; the user must make them
// only while no item is in flight, which the block itself does not enforce.
module text_glyph_layout_unit #(
	parameter int unsigned COORD_BITS = tgl_pkg::COORD_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             item_valid,
	output logic                             item_ready,
	input  tgl_pkg::item_t                   item,
	output logic                             result_valid,
	input  logic                             result_ready,
	output tgl_pkg::result_t                 result,
	input  logic                             cfg_we,
	input  logic [tgl_pkg::CFG_IDX_BITS-1:0] cfg_index,
	input  logic [31:0]                      cfg_data
);

	tgl_pkg::cfg_t    cfg;
	tgl_pkg::item_t   item_s1;
	tgl_pkg::result_t result_s2;
	tgl_pkg::result_t res;
	logic             valid_s1, valid_s2;
	logic             adv, step, emit;

	tgl_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	tgl_core #(.COORD_BITS(COORD_BITS)) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.item   (item_s1),
		.cfg    (cfg),
		.emit   (emit),
		.res    (res)
	);

	// output register free or being drained this cycle
	assign adv        = !valid_s2 || result_ready;
	assign step       = valid_s1 && adv;
	assign item_ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (item_ready) begin
				valid_s1 <= item_valid;
			end
			if (adv) begin
				valid_s2 <= step && emit;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && item_ready) begin
			item_s1 <= item;
		end
		if (step && emit) begin
			result_s2 <= res;
		end
	end

	assign result_valid = valid_s2;
	assign result       = result_s2;

endmodule

// ===== rtl/core/tgl_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// tgl_cfg_regs
// Configuration register file with a plain indexed write port.
// ----------------------------------------------------------------------------
module tgl_cfg_regs (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [tgl_pkg::CFG_IDX_BITS-1:0]    cfg_index,
	input  logic [31:0]                         cfg_data,
	output tgl_pkg::cfg_t                       cfg
);

	tgl_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pad_horizontal <= '0;
			cfg_q.pad_vertical   <= '0;
			cfg_q.line_gap       <= '0;
			cfg_q.screen_width   <= tgl_pkg::SCREEN_W_RST;
			cfg_q.pass_mode      <= 1'b0;
			cfg_q.glyph_color    <= tgl_pkg::FG_RST;
			cfg_q.box_color      <= tgl_pkg::BG_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				tgl_pkg::REG_PAD_H:    cfg_q.pad_horizontal <= cfg_data[7:0];
				tgl_pkg::REG_PAD_V:    cfg_q.pad_vertical   <= cfg_data[7:0];
				tgl_pkg::REG_LINE_GAP: cfg_q.line_gap       <= cfg_data[7:0];
				tgl_pkg::REG_SCREEN_W: cfg_q.screen_width   <= cfg_data[11:0];
				tgl_pkg::REG_MODE:     cfg_q.pass_mode      <= cfg_data[0];
				tgl_pkg::REG_FG:       cfg_q.glyph_color    <= cfg_data;
				tgl_pkg::REG_BG:       cfg_q.box_color      <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== rtl/core/tgl_core.sv =====
// ----------------------------------------------------------------------------
// tgl_core
// Cursor state and combinational layout of one item into a quad, a box or no result.
// ----------------------------------------------------------------------------
module tgl_core #(
	parameter int unsigned COORD_BITS = tgl_pkg::COORD_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  tgl_pkg::item_t    item,
	input  tgl_pkg::cfg_t     cfg,
	output logic              emit,
	output tgl_pkg::result_t  res
);

	localparam int unsigned SW = COORD_BITS + 16;

	typedef logic signed [COORD_BITS-1:0] coord_t;
	typedef logic signed [SW-1:0]         wide_t;

	localparam wide_t SAT_MAX = {{(SW-COORD_BITS+1){1'b0}}, {(COORD_BITS-1){1'b1}}};
	localparam wide_t SAT_MIN = ~SAT_MAX;

	function automatic coord_t sat(wide_t v);
		if (v > SAT_MAX) return coord_t'(SAT_MAX);
		if (v < SAT_MIN) return coord_t'(SAT_MIN);
		return v[COORD_BITS-1:0];
	endfunction

	function automatic wide_t wx(coord_t c);
		return wide_t'(c);
	endfunction

	coord_t cx_q, cy_q, ssx_q, ssy_q, lsx_q, lsy_q;
	logic   in_str_q;

	coord_t cx_n, cy_n, ssx_n, ssy_n, lsx_n, lsy_n;
	logic   in_str_n;

	coord_t lsx_e, lsy_e, ssx_e, ssy_e;
	coord_t cy_adv, cx1, cy1, cx_inc;
	wide_t  padh, padv, lim, box_l, box_t, box_r, box_b, gl, gt;
	logic   nl, printable, wrap;
	logic [8:0]         row_h;
	logic signed [25:0] prod_a;
	logic signed [19:0] prod_b;
	tgl_pkg::tex_t      tex;
	tgl_pkg::result_t   res_box, res_glyph;

	always_comb begin
		// a closed string reopens at the current cursor
		lsx_e = in_str_q ? lsx_q : cx_q;
		lsy_e = in_str_q ? lsy_q : cy_q;
		ssx_e = in_str_q ? ssx_q : cx_q;
		ssy_e = in_str_q ? ssy_q : cy_q;

		padh = wide_t'(cfg.pad_horizontal);
		padv = wide_t'(cfg.pad_vertical);
		lim  = wide_t'(cfg.screen_width) - (padh <<< 1);

		nl        = (item.char_code == tgl_pkg::CHAR_NL);
		printable = (item.char_code >= tgl_pkg::CHAR_FIRST)
			&& (item.char_code <= tgl_pkg::CHAR_LAST);
		wrap      = nl || (wx(cx_q) + wide_t'(10) > lim);

		cy_adv = sat(wx(cy_q) + wide_t'(15) + wide_t'(cfg.line_gap));
		cx1    = wrap ? '0 : cx_q;
		cy1    = wrap ? cy_adv : cy_q;
		cx_inc = sat(wx(cx1) + wide_t'(10));

		row_h  = 9'd15 + {1'b0, cfg.line_gap};
		prod_a = item.arg_a * $signed({1'b0, row_h});
		prod_b = item.arg_b * 20'sd10;

		box_l = wx(lsx_e) + padh - wide_t'(2);
		box_t = wx(lsy_e) + padv - wide_t'(2);
		box_r = wx(cx_q) + padh;
		box_b = wx(cy_q) + padv + wide_t'(15);

		res_box            = '0;
		res_box.kind       = tgl_pkg::KIND_BOX;
		res_box.left       = box_l[15:0];
		res_box.top        = box_t[15:0];
		res_box.right      = box_r[15:0];
		res_box.bottom     = box_b[15:0];
		res_box.color      = cfg.box_color;

		gl  = wx(cx1) + padh;
		gt  = wx(cy1) + padv;
		tex = tgl_pkg::glyph_tex(item.char_code);

		res_glyph.kind       = tgl_pkg::KIND_GLYPH;
		res_glyph.left       = gl[15:0];
		res_glyph.top        = gt[15:0];
		res_glyph.right      = gl[15:0] + 16'sd8;
		res_glyph.bottom     = gt[15:0] + 16'sd15;
		res_glyph.tex_left   = tex.tex_left;
		res_glyph.tex_top    = tex.tex_top;
		res_glyph.tex_right  = tex.tex_right;
		res_glyph.tex_bottom = tex.tex_bottom;
		res_glyph.color      = cfg.glyph_color;

		cx_n     = cx_q;
		cy_n     = cy_q;
		ssx_n    = ssx_q;
		ssy_n    = ssy_q;
		lsx_n    = lsx_q;
		lsy_n    = lsy_q;
		in_str_n = in_str_q;
		emit     = 1'b0;
		res      = res_box;

		unique case (item.opcode)
			tgl_pkg::OP_CHAR: begin
				in_str_n = 1'b1;
				ssx_n    = ssx_e;
				ssy_n    = ssy_e;
				lsx_n    = lsx_e;
				lsy_n    = lsy_e;
				if (nl || printable) begin
					if (wrap) begin
						emit  = !cfg.pass_mode;
						cx_n  = '0;
						cy_n  = cy_adv;
						lsx_n = '0;
						lsy_n = cy_adv;
					end
					if (!nl) begin
						if (cfg.pass_mode) begin
							emit = 1'b1;
							res  = res_glyph;
						end
						cx_n = cx_inc;
					end
				end
			end
			tgl_pkg::OP_END: begin
				in_str_n = 1'b0;
				ssx_n    = ssx_e;
				ssy_n    = ssy_e;
				lsx_n    = lsx_e;
				lsy_n    = lsy_e;
				if (!cfg.pass_mode) begin
					emit = (lsx_e != cx_q);
					cx_n = ssx_e;
					cy_n = ssy_e;
				end
			end
			tgl_pkg::OP_ROW: begin
				cy_n = sat(wide_t'(prod_a));
				cx_n = sat(wide_t'(prod_b));
			end
			tgl_pkg::OP_PIX: begin
				cx_n = sat(wide_t'(item.arg_a));
				cy_n = sat(wide_t'(item.arg_b));
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cx_q     <= '0;
			cy_q     <= '0;
			ssx_q    <= '0;
			ssy_q    <= '0;
			lsx_q    <= '0;
			lsy_q    <= '0;
			in_str_q <= 1'b0;
		end else if (step) begin
			cx_q     <= cx_n;
			cy_q     <= cy_n;
			ssx_q    <= ssx_n;
			ssy_q    <= ssy_n;
			lsx_q    <= lsx_n;
			lsy_q    <= lsy_n;
			in_str_q <= in_str_n;
		end
	end

endmodule

// ===== rtl/core/tgl_checker.sv =====
// ----------------------------------------------------------------------------
// tgl_checker
// Port-level checks on the layout unit, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tgl_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             result_valid,
	input logic             result_ready,
	input tgl_pkg::result_t result
);

	logic is_box, is_glyph;
	logic box_tex_zero, glyph_size_ok, glyph_cell_ok;

	assign is_box   = result_valid && (result.kind == tgl_pkg::KIND_BOX);
	assign is_glyph = result_valid && (result.kind == tgl_pkg::KIND_GLYPH);

	assign box_tex_zero = (result.tex_left == 7'd0) && (result.tex_top == 8'd0)
		&& (result.tex_right == 7'd0) && (result.tex_bottom == 8'd0);
	assign glyph_size_ok = (result.right == result.left + 16'sd8)
		&& (result.bottom == result.top + 16'sd15);
	assign glyph_cell_ok = (result.tex_left <= 7'd72) && (result.tex_top <= 8'd144)
		&& (result.tex_right == result.tex_left + 7'd8)
		&& (result.tex_bottom == result.tex_top + 8'd15);

	// hold a stalled result
	`ASSERT_CLK(a_result_hold, result_valid && !result_ready |=> result_valid && $stable(result), "stalled result changed")

	`ASSERT_CLK(a_box_tex_zero, is_box |-> box_tex_zero, "box carries texture coordinates")

	`ASSERT_CLK(a_glyph_size, is_glyph |-> glyph_size_ok, "glyph quad has wrong size")

	`ASSERT_CLK(a_glyph_cell, is_glyph |-> glyph_cell_ok, "glyph cell outside font sheet")

endmodule

bind text_glyph_layout_unit tgl_checker u_tgl_checker (.*);
